>>> rtl/dogx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dogx_pkg
// Shared types and constants for the 3x3x3 DoG extremum detector.
// ----------------------------------------------------------------------------
package dogx_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int NUM_PLANES  = 3;
	localparam int MAX_LINE    = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int COL_W       = $clog2(MAX_LINE);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int DIM_W       = 11;
	localparam int THR_W       = 15;
	localparam int EDGE_MARGIN = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int COLW_BITS   = NUM_PLANES * SAMPLE_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [2:0][2:0]            plane_win_t;
	typedef logic [COLW_BITS-1:0]          col_word_t;

	typedef struct packed {
		logic all_gt;
		logic all_lt;
	} lane_flags_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_CONTRAST     = 2'd2
	} cfg_reg_t;

	// saturate a frame dimension to [1, lim]
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/dogx_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dogx_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dogx_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/dogx_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dogx_lane
// Compares the window centre against the 3x3 cells of one plane.
// ----------------------------------------------------------------------------
module dogx_lane (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire dogx_pkg::plane_win_t cells,
	input  wire dogx_pkg::sample_t   centre,
	input  wire logic                skip_centre,
	output      dogx_pkg::lane_flags_t flags_s3
);

	logic [8:0] gt_bits;
	logic [8:0] lt_bits;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (skip_centre && i == 1 && j == 1) begin
					gt_bits[i*3+j] = 1'b1;
					lt_bits[i*3+j] = 1'b1;
				end else begin
					gt_bits[i*3+j] = $signed(centre) > $signed(cells[i][j]);
					lt_bits[i*3+j] = $signed(centre) < $signed(cells[i][j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3.all_gt <= &gt_bits;
			flags_s3.all_lt <= &lt_bits;
		end
	end

endmodule
`default_nettype wire

>>> rtl/dog_extremum_detector_3x3x3_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dog_extremum_detector_3x3x3_unit
// Streaming 3x3x3 difference-of-Gaussian extremum detector.
// ----------------------------------------------------------------------------
// Takes one word per clock (below, middle, above sample) in raster order and
// returns one word per input word, judging the window centre one row and one
// column back. Throughput is one word per cycle while out_ready does not stall
// the pipeline. An accepted word passes the line-store read at the accept
// edge, then the window shift, the three plane lanes comparing in parallel,
// and the merge into the output register. The line stores share one 1024 x 96
// RAM whose read-modify-write runs at one column per cycle unless stalled; a
// same-column write/read collision is forwarded. Column and row restart at the
// configured width/height; frame_start forces 0,0.
// ----------------------------------------------------------------------------
module dog_extremum_detector_3x3x3_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [dogx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dogx_pkg::THR_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire dogx_pkg::sample_t                 below_sample,
	input  wire dogx_pkg::sample_t                 middle_sample,
	input  wire dogx_pkg::sample_t                 above_sample,
	input  wire logic                              frame_start,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [dogx_pkg::ROW_W-1:0]        centre_row,
	output      logic [dogx_pkg::COL_W-1:0]        centre_col,
	output      dogx_pkg::sample_t                 centre_value,
	output      logic                              is_extremum,
	output      logic                              is_maximum
);

	// configuration
	logic [dogx_pkg::DIM_W-1:0] lw_q;
	logic [dogx_pkg::DIM_W-1:0] fh_q;
	logic [dogx_pkg::THR_W-1:0] thr_q;
	logic [dogx_pkg::DIM_W-1:0] w_use;
	logic [dogx_pkg::DIM_W-1:0] h_use;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q  <= dogx_pkg::DIM_W'(640);
			fh_q  <= dogx_pkg::DIM_W'(480);
			thr_q <= dogx_pkg::THR_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dogx_pkg::REG_LINE_WIDTH: begin
					lw_q <= cfg_data[dogx_pkg::DIM_W-1:0];
				end
				dogx_pkg::REG_FRAME_HEIGHT: begin
					fh_q <= cfg_data[dogx_pkg::DIM_W-1:0];
				end
				dogx_pkg::REG_CONTRAST: begin
					thr_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign w_use = dogx_pkg::clamp_dim(lw_q, dogx_pkg::DIM_W'(dogx_pkg::MAX_LINE));
	assign h_use = dogx_pkg::clamp_dim(fh_q, dogx_pkg::DIM_W'(dogx_pkg::MAX_ROWS));

	// pipeline control
	logic adv;
	logic accept;
	logic valid_s1, valid_s2, valid_s3;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	// position tracking
	logic [dogx_pkg::ROW_W-1:0] row_q, r_raw, r_cur, row_next;
	logic [dogx_pkg::COL_W-1:0] col_q, c_raw, c_cur, col_next;
	logic [dogx_pkg::DIM_W-1:0] r_inc, c_inc;

	always_comb begin
		r_raw = frame_start ? '0 : row_q;
		c_raw = frame_start ? '0 : col_q;
		r_cur = ({1'b0, r_raw} >= h_use) ? '0 : r_raw;
		c_cur = ({1'b0, c_raw} >= w_use) ? '0 : c_raw;
		r_inc = {1'b0, r_cur} + dogx_pkg::DIM_W'(1);
		c_inc = {1'b0, c_cur} + dogx_pkg::DIM_W'(1);
		if (c_inc >= w_use) begin
			col_next = '0;
			row_next = (r_inc >= h_use) ? '0 : r_inc[dogx_pkg::ROW_W-1:0];
		end else begin
			col_next = c_inc[dogx_pkg::COL_W-1:0];
			row_next = r_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= row_next;
			col_q <= col_next;
		end
	end

	// stage 1: line store read
	logic [dogx_pkg::ROW_W-1:0] r_s1, r_s2;
	logic [dogx_pkg::COL_W-1:0] c_s1, c_s2;
	dogx_pkg::col_word_t        fresh_s1;
	dogx_pkg::col_word_t        one_back, two_back;
	logic [2*dogx_pkg::COLW_BITS-1:0] ram_rd, ram_wr, byp_data_q;
	logic                       ram_we;
	logic                       byp_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1     <= r_cur;
			c_s1     <= c_cur;
			fresh_s1 <= {above_sample, middle_sample, below_sample};
		end
	end

	assign ram_we = adv && valid_s1;
	assign ram_wr = {one_back, fresh_s1};

	dogx_ram #(
		.WIDTH(2 * dogx_pkg::COLW_BITS),
		.DEPTH(dogx_pkg::MAX_LINE)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(c_s1),
		.wr_data(ram_wr),
		.rd_en  (accept),
		.rd_addr(c_cur),
		.rd_data(ram_rd)
	);

	// same-column write at the read edge: forward the written word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (accept) begin
			byp_q <= ram_we && (c_s1 == c_cur);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byp_data_q <= ram_wr;
		end
	end

	assign one_back = byp_q ? byp_data_q[dogx_pkg::COLW_BITS-1:0]
		: ram_rd[dogx_pkg::COLW_BITS-1:0];
	assign two_back = byp_q ? byp_data_q[2*dogx_pkg::COLW_BITS-1:dogx_pkg::COLW_BITS]
		: ram_rd[2*dogx_pkg::COLW_BITS-1:dogx_pkg::COLW_BITS];

	// stage 2: window
	dogx_pkg::plane_win_t win_q [dogx_pkg::NUM_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < dogx_pkg::NUM_PLANES; p++) begin
				win_q[p] <= '0;
			end
		end else if (ram_we) begin
			for (int p = 0; p < dogx_pkg::NUM_PLANES; p++) begin
				for (int i = 0; i < 3; i++) begin
					win_q[p][i][0] <= win_q[p][i][1];
					win_q[p][i][1] <= win_q[p][i][2];
				end
				win_q[p][0][2] <= two_back[p*dogx_pkg::SAMPLE_BITS +: dogx_pkg::SAMPLE_BITS];
				win_q[p][1][2] <= one_back[p*dogx_pkg::SAMPLE_BITS +: dogx_pkg::SAMPLE_BITS];
				win_q[p][2][2] <= fresh_s1[p*dogx_pkg::SAMPLE_BITS +: dogx_pkg::SAMPLE_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2 <= r_s1;
			c_s2 <= c_s1;
		end
	end

	dogx_pkg::sample_t         centre;
	logic [dogx_pkg::SAMPLE_BITS:0] mag;
	logic                      in_frame, border_ok, cand;

	always_comb begin
		centre    = win_q[1][1][1];
		mag       = centre[dogx_pkg::SAMPLE_BITS-1]
			? -{centre[dogx_pkg::SAMPLE_BITS-1], centre}
			: {centre[dogx_pkg::SAMPLE_BITS-1], centre};
		in_frame  = (r_s2 != '0) && (c_s2 != '0);
		border_ok = (r_s2 >= dogx_pkg::ROW_W'(dogx_pkg::EDGE_MARGIN + 1))
			&& (c_s2 >= dogx_pkg::COL_W'(dogx_pkg::EDGE_MARGIN + 1))
			&& (({2'b0, r_s2} + 12'(dogx_pkg::EDGE_MARGIN - 1)) < {1'b0, h_use})
			&& (({2'b0, c_s2} + 12'(dogx_pkg::EDGE_MARGIN - 1)) < {1'b0, w_use});
		cand      = border_ok && (mag > {2'b0, thr_q});
	end

	// stage 3: plane lanes
	dogx_pkg::lane_flags_t flags_s3 [dogx_pkg::NUM_PLANES];
	logic [dogx_pkg::ROW_W-1:0] row_s3;
	logic [dogx_pkg::COL_W-1:0] col_s3;
	dogx_pkg::sample_t          value_s3;
	logic                       cand_s3;

	for (genvar p = 0; p < dogx_pkg::NUM_PLANES; p++) begin : g_lane
		dogx_lane u_lane (
			.clk        (clk),
			.en         (adv),
			.cells      (win_q[p]),
			.centre     (centre),
			.skip_centre(p == 1),
			.flags_s3   (flags_s3[p])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s3   <= r_s2 - dogx_pkg::ROW_W'(1);
			col_s3   <= c_s2 - dogx_pkg::COL_W'(1);
			value_s3 <= in_frame ? centre : '0;
			cand_s3  <= cand;
		end
	end

	// merge into output word
	logic all_gt, all_lt;

	always_comb begin
		all_gt = 1'b1;
		all_lt = 1'b1;
		for (int p = 0; p < dogx_pkg::NUM_PLANES; p++) begin
			all_gt = all_gt & flags_s3[p].all_gt;
			all_lt = all_lt & flags_s3[p].all_lt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			centre_row   <= row_s3;
			centre_col   <= col_s3;
			centre_value <= value_s3;
			is_extremum  <= cand_s3 && (all_gt || all_lt);
			is_maximum   <= cand_s3 && all_gt;
		end
	end

	// checks
	a_max_is_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_maximum |-> is_extremum)
		else $error("maximum flagged without extremum");

	a_ext_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_extremum |->
			centre_row >= dogx_pkg::ROW_W'(dogx_pkg::EDGE_MARGIN)
			&& centre_col >= dogx_pkg::COL_W'(dogx_pkg::EDGE_MARGIN)
			&& centre_value != '0)
		else $error("extremum in border or at zero value");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> valid_s1 && r_s1 == '0 && c_s1 == '0)
		else $error("frame start did not restart position");

endmodule
`default_nettype wire

>>> bench/dog_extremum_detector_3x3x3_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dog_extremum_detector_3x3x3_unit_tb
// Self-checking bench for the streaming 3x3x3 DoG extremum detector.
// ----------------------------------------------------------------------------
// A short directed table runs first. It covers the default geometry after
// reset, full-scale samples, frame_start, saturated line widths and frame
// heights, masked register bits and an unmapped register index. Random frames
// follow in several geometries and thresholds. Their sample fills are full
// range, narrow, planted peaks, or plateaus with off-by-one spikes. Each
// accepted word goes through a local model of the line stores and the window.
// The model's results are queued and compared field by field with the
// results that the block returns. Both handshakes idle at random, and the
// output side holds off once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module dog_extremum_detector_3x3x3_unit_tb;
	import dogx_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		sample_t          value;
		logic             ext;
		logic             maxi;
	} centre_result_t;

	typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [THR_W-1:0]     reg_data;
		sample_t              below;
		sample_t              middle;
		sample_t              above;
		logic                 fs;
		logic                 typed;
		centre_result_t       want;
	} step_t;

	typedef enum logic [1:0] {FILL_FULL, FILL_NARROW, FILL_PEAKS, FILL_PLATEAU} fill_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	sample_t              below_sample;
	sample_t              middle_sample;
	sample_t              above_sample;
	logic                 frame_start;
	logic                 out_valid;
	logic                 out_ready;
	logic [ROW_W-1:0]     centre_row;
	logic [COL_W-1:0]     centre_col;
	sample_t              centre_value;
	logic                 is_extremum;
	logic                 is_maximum;

	dog_extremum_detector_3x3x3_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.below_sample(below_sample),
		.middle_sample(middle_sample),
		.above_sample(above_sample),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.centre_row(centre_row),
		.centre_col(centre_col),
		.centre_value(centre_value),
		.is_extremum(is_extremum),
		.is_maximum(is_maximum)
	);

	// local copy of the detector state
	logic [DIM_W-1:0] width_reg = 11'd640;
	logic [DIM_W-1:0] height_reg = 11'd480;
	logic [THR_W-1:0] thresh_reg = 15'd64;
	bit signed [SAMPLE_BITS-1:0] line_one [NUM_PLANES][MAX_LINE];
	bit signed [SAMPLE_BITS-1:0] line_two [NUM_PLANES][MAX_LINE];
	bit signed [SAMPLE_BITS-1:0] win [NUM_PLANES][3][3];
	int row_pos = 0;
	int col_pos = 0;

	centre_result_t pending_centres [$];
	centre_result_t due_word;
	int  mismatches = 0;
	int  words_checked = 0;
	bit  held_off = 1'b0;
	bit  tx_idle = 1'b1;
	bit  rx_idle = 1'b1;
	int  rx_stall = 0;
	int  rx_cycle = 0;
	step_t opening [$];

	always #6 clk = ~clk;

	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int idle_span(input bit on);
		int k;
		k = $urandom_range(0, 99);
		if (!on || k < 60)
			return 0;
		else if (k < 88)
			return $urandom_range(1, 3);
		else if (k < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	function automatic void load_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [THR_W-1:0] data);
		case (idx)
			REG_LINE_WIDTH: width_reg = data[DIM_W-1:0];
			REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
			REG_CONTRAST: thresh_reg = data;
			default: ;
		endcase
	endfunction

	function automatic centre_result_t judge_pixel(input sample_t b, input sample_t m,
			input sample_t a, input logic fs);
		int w, h, r, c, cr, cc, p, i, j, centre, mag, v;
		bit in_frame, all_gt, all_lt;
		sample_t fresh [NUM_PLANES];
		sample_t one_back, two_back;
		centre_result_t res;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_LINE) ? MAX_LINE : int'(width_reg));
		h = (height_reg == 0) ? 1 : ((height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg));
		r = row_pos;
		c = col_pos;
		if (fs) begin
			r = 0;
			c = 0;
		end
		if (c >= w)
			c = 0;
		if (r >= h)
			r = 0;
		fresh[0] = b;
		fresh[1] = m;
		fresh[2] = a;
		for (p = 0; p < NUM_PLANES; p++) begin
			one_back = line_one[p][c];
			two_back = line_two[p][c];
			for (i = 0; i < 3; i++) begin
				win[p][i][0] = win[p][i][1];
				win[p][i][1] = win[p][i][2];
			end
			win[p][0][2] = two_back;
			win[p][1][2] = one_back;
			win[p][2][2] = fresh[p];
			line_two[p][c] = one_back;
			line_one[p][c] = fresh[p];
		end
		cr = r - 1;
		cc = c - 1;
		in_frame = (r >= 1) && (c >= 1);
		centre = win[1][1][1];
		mag = (centre < 0) ? -centre : centre;
		res = '0;
		if (in_frame && cr >= EDGE_MARGIN && cr < h - EDGE_MARGIN && cc >= EDGE_MARGIN &&
				cc < w - EDGE_MARGIN && mag > int'(thresh_reg)) begin
			all_gt = 1'b1;
			all_lt = 1'b1;
			for (p = 0; p < NUM_PLANES; p++)
				for (i = 0; i < 3; i++)
					for (j = 0; j < 3; j++)
						if (!(p == 1 && i == 1 && j == 1)) begin
							v = win[p][i][j];
							if (!(centre > v))
								all_gt = 1'b0;
							if (!(centre < v))
								all_lt = 1'b0;
						end
			if (all_gt) begin
				res.ext = 1'b1;
				res.maxi = 1'b1;
			end else if (all_lt) begin
				res.ext = 1'b1;
			end
		end
		res.row = cr[ROW_W-1:0];
		res.col = cc[COL_W-1:0];
		res.value = in_frame ? sample_t'(centre) : '0;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		row_pos = r;
		col_pos = c;
		return res;
	endfunction

	function automatic void compare_field(input string fname, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 60)
				$display("%0t ns: %s expected %0d, got %0d", $time, fname, want, got);
		end
	endfunction

	function automatic step_t write_step(input logic [CFG_IDX_W-1:0] idx,
			input logic [THR_W-1:0] data);
		step_t s;
		s = '0;
		s.kind = STEP_WRITE;
		s.reg_idx = idx;
		s.reg_data = data;
		return s;
	endfunction

	function automatic step_t pixel_step(input sample_t b, input sample_t m, input sample_t a,
			input logic fs);
		step_t s;
		s = '0;
		s.kind = STEP_PIXEL;
		s.below = b;
		s.middle = m;
		s.above = a;
		s.fs = fs;
		return s;
	endfunction

	// centre lies outside the frame: value and flags are zero
	function automatic step_t outside_step(input sample_t b, input sample_t m, input sample_t a,
			input logic fs, input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		step_t s;
		s = pixel_step(b, m, a, fs);
		s.typed = 1'b1;
		s.want.row = row;
		s.want.col = col;
		return s;
	endfunction

	function automatic fill_mode_t pick_fill();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40)
			return FILL_PEAKS;
		else if (k < 65)
			return FILL_PLATEAU;
		else if (k < 85)
			return FILL_FULL;
		return FILL_NARROW;
	endfunction

	task automatic send_pixel(input sample_t b, input sample_t m, input sample_t a,
			input logic fs, input bit typed, input centre_result_t typed_word);
		int gap;
		centre_result_t predicted;
		gap = idle_span(tx_idle);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		below_sample = b;
		middle_sample = m;
		above_sample = a;
		frame_start = fs;
		in_valid = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = judge_pixel(b, m, a, fs);
		if (typed)
			predicted = typed_word;
		pending_centres = {pending_centres, predicted};
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_centres.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		load_setting(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_run(input int count, input fill_mode_t mode, input bit fs_first);
		int k, base;
		sample_t b, m, a;
		logic fs;
		case ($urandom_range(0, 5))
			0: base = 32766;
			1: base = -32767;
			default: base = int'($urandom_range(0, 1000)) - 500;
		endcase
		for (k = 0; k < count; k++) begin
			if (k % 100 == 0)
				tx_idle = ($urandom_range(0, 3) != 0);
			case (mode)
				FILL_FULL: begin
					b = sample_t'($urandom);
					m = sample_t'($urandom);
					a = sample_t'($urandom);
				end
				FILL_NARROW: begin
					b = sample_t'(int'($urandom_range(0, 8)) - 4);
					m = sample_t'(int'($urandom_range(0, 8)) - 4);
					a = sample_t'(int'($urandom_range(0, 8)) - 4);
				end
				FILL_PEAKS: begin
					b = sample_t'(int'($urandom_range(0, 4000)) - 2000);
					m = sample_t'(int'($urandom_range(0, 4000)) - 2000);
					a = sample_t'(int'($urandom_range(0, 4000)) - 2000);
					if ($urandom_range(0, 6) == 0)
						case ($urandom_range(0, 3))
							0: m = 16'h7FFF;
							1: m = 16'h8000;
							2: m = sample_t'($urandom_range(3000, 32767));
							default: m = sample_t'(-int'($urandom_range(3000, 32767)));
						endcase
				end
				default: begin
					b = sample_t'(base);
					m = sample_t'(base);
					a = sample_t'(base);
					if ($urandom_range(0, 7) == 0)
						m = sample_t'($urandom_range(0, 1) ? base + 1 : base - 1);
					if ($urandom_range(0, 15) == 0)
						b = sample_t'(base + 1);
					if ($urandom_range(0, 15) == 0)
						a = sample_t'(base - 1);
				end
			endcase
			fs = (k == 0 && fs_first) || ($urandom_range(0, 499) == 0);
			send_pixel(b, m, a, fs, 1'b0, '0);
		end
	endtask

	// output side: random stalls, plus one long hold-off to back up the input
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 150 == 0)
				rx_idle = ($urandom_range(0, 3) != 0);
			if (!held_off && words_checked >= 400) begin
				held_off = 1'b1;
				rx_stall = 120;
			end
			if (rx_stall > 0) begin
				out_ready = 1'b0;
				rx_stall--;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				rx_stall = idle_span(1'b1);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_centres.size() == 0) begin
				mismatches++;
				if (mismatches <= 60)
					$display("%0t ns: unexpected word, row %0d col %0d", $time,
						centre_row, centre_col);
			end else begin
				due_word = pending_centres.pop_front();
				compare_field("centre_row", due_word.row, centre_row);
				compare_field("centre_col", due_word.col, centre_col);
				compare_field("centre_value", due_word.value, centre_value);
				compare_field("is_extremum", due_word.ext, is_extremum);
				compare_field("is_maximum", due_word.maxi, is_maximum);
			end
			words_checked++;
		end
	end

	initial begin
		int k, phase, w, h, f, frames, small_items, thr;
		step_t st;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LINE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		below_sample = '0;
		middle_sample = '0;
		above_sample = '0;
		frame_start = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		opening = {
			outside_step(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 10'd1023, 10'd1023),
			outside_step(16'h8000, 16'h8000, 16'h8000, 1'b0, 10'd1023, 10'd0),
			outside_step(16'h0000, 16'hFFFF, 16'h0001, 1'b1, 10'd1023, 10'd1023),
			pixel_step(16'h5555, 16'hAAAA, 16'h5555, 1'b0),
			pixel_step(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0),
			write_step(REG_LINE_WIDTH, 15'h7800),
			write_step(REG_FRAME_HEIGHT, 15'd3),
			outside_step(16'h1234, 16'h8001, 16'h7FFE, 1'b1, 10'd1023, 10'd1023),
			outside_step(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 10'd0, 10'd1023),
			outside_step(16'h8000, 16'h7FFF, 16'h8000, 1'b0, 10'd1, 10'd1023),
			outside_step(16'h0001, 16'h0001, 16'h0001, 1'b0, 10'd1023, 10'd1023),
			write_step(REG_UNMAPPED, 15'h7FFF),
			write_step(REG_FRAME_HEIGHT, 15'd0),
			outside_step(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 10'd1023, 10'd1023),
			outside_step(16'h0F0F, 16'hF0F0, 16'h0F0F, 1'b0, 10'd1023, 10'd1023),
			write_step(REG_LINE_WIDTH, 15'h07FF),
			write_step(REG_FRAME_HEIGHT, 15'h7FFF),
			write_step(REG_CONTRAST, 15'h7FFF),
			outside_step(16'h8000, 16'h8000, 16'h8000, 1'b1, 10'd1023, 10'd1023),
			outside_step(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 10'd1023, 10'd0),
			outside_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 10'd1023, 10'd1)
		};
		foreach (opening[k]) begin
			st = opening[k];
			if (st.kind == STEP_WRITE) begin
				settle();
				write_reg(st.reg_idx, st.reg_data);
			end else begin
				send_pixel(st.below, st.middle, st.above, st.fs, st.typed, st.want);
			end
		end

		// full-width lines: column count runs past the last column once
		settle();
		write_reg(REG_LINE_WIDTH, 15'h07FF | (15'($urandom_range(0, 15)) << 11));
		write_reg(REG_FRAME_HEIGHT, 15'($urandom_range(2, 8)));
		write_reg(REG_CONTRAST, 15'($urandom_range(0, 32767)));
		send_run(1030, FILL_FULL, 1'b1);

		small_items = 0;
		phase = 0;
		while (small_items < 300) begin
			w = $urandom_range(11, 16);
			h = $urandom_range(11, 16);
			case (phase)
				0: thr = $urandom_range(0, 200);
				1: thr = 0;
				default: begin
					k = $urandom_range(0, 99);
					if (k < 35)
						thr = $urandom_range(0, 200);
					else if (k < 50)
						thr = 0;
					else if (k < 60)
						thr = 32767;
					else
						thr = $urandom_range(0, 32767);
				end
			endcase
			settle();
			write_reg(REG_LINE_WIDTH, 15'(w) | (15'($urandom_range(0, 15)) << 11));
			write_reg(REG_FRAME_HEIGHT, 15'(h) | (15'($urandom_range(0, 15)) << 11));
			write_reg(REG_CONTRAST, 15'(thr));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNMAPPED, 15'($urandom));
			frames = 1;
			for (f = 0; f < frames; f++) begin
				send_run(w * h, pick_fill(), (f == 0) || ($urandom_range(0, 1) == 1));
				small_items += w * h;
			end
			phase++;
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_centres.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_centres.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
rtl/dogx_pkg.sv
rtl/dogx_ram.sv
rtl/dogx_lane.sv
rtl/dog_extremum_detector_3x3x3_unit.sv
bench/dog_extremum_detector_3x3x3_unit_tb.sv
